// ===== hw/rtl/crts_pkg.sv =====
package crts_pkg;

  localparam int unsigned MaxCandDefault = 8;

  // item field widths
  localparam int OpW     = 2;
  localparam int CoordW  = 24;
  localparam int ModeW   = 2;
  localparam int StartW  = 4;
  localparam int DirW    = 16;
  localparam int CosW    = 17;
  localparam int DistW   = 50;
  localparam int IdxOutW = 3;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 50;

  // datapath widths
  localparam int OffW   = CoordW + 1;   // candidate minus origin
  localparam int DotW   = 42;           // |dot| < 3 * 2^39
  localparam int DmagW  = DotW - 1;
  localparam int CcW    = 2 * CosW - 1; // cosine squared, up to 2^32
  localparam int ChunkW = 26;           // operand slice for wide products
  localparam int MulW   = ChunkW + 1;   // signed multiplier operand
  localparam int ProdW  = 2 * MulW;
  localparam int AccW   = 84;           // holds |dot|^2 - cos^2 * d2

  typedef enum logic [OpW-1:0] {
    OP_ORIGIN = 2'd0,
    OP_DIR    = 2'd1,
    OP_CAND   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_FIRST      = 2'd0,
    MODE_FARTHEST   = 2'd1,
    MODE_NEAR_CONE  = 2'd2,
    MODE_NEAR_RANGE = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DIST = 2'd0,
    CFG_MAX_DIST = 2'd1,
    CFG_CONE_COS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [OpW-1:0]           op;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [ModeW-1:0]         query_mode;
    logic signed [StartW-1:0] start_after;
    logic                     last;
  } cand_item_t;

  typedef struct packed {
    logic               found;
    logic [IdxOutW-1:0] best_index;
    logic [DistW-1:0]   best_dist_sq;
  } result_item_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_26 = 2'd1,
    SH_27 = 2'd2,
    SH_52 = 2'd3
  } mac_shift_e;

  typedef struct packed {
    logic       en;
    logic       clear;
    logic       sub;
    mac_shift_e shift;
  } mac_ctl_t;

endpackage

// ===== hw/rtl/crts_stream_if.sv =====
interface crts_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/crts_mac.sv =====
module crts_mac import crts_pkg::*; (
  input  logic                   clk_i,
  input  mac_ctl_t               ctl_i,
  input  logic signed [MulW-1:0] a_i,
  input  logic signed [MulW-1:0] b_i,
  output logic signed [AccW-1:0] acc_o
);

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  base;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW-1:0]  acc_q;

  assign prod     = a_i * b_i;
  assign prod_ext = AccW'(prod);

  always_comb begin
    case (ctl_i.shift)
      SH_0:    term = prod_ext;
      SH_26:   term = prod_ext <<< 26;
      SH_27:   term = prod_ext <<< 27;
      SH_52:   term = prod_ext <<< 52;
      default: term = prod_ext;
    endcase
    base  = ctl_i.clear ? '0 : acc_q;
    acc_d = ctl_i.sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/cone_range_target_select.sv =====
// Channel   Dir  Handshake      Payload
// cand_i    in   valid/ready    op, coord_x/y/z, query_mode, start_after, last
// result_o  out  valid/ready    found, best_index, best_dist_sq
// cfg       in   cfg_we_i only  cfg_idx_i, cfg_wdata_i (no read-back)
//
// Origin and direction items are taken in ST_IDLE. A candidate within the limit
// runs 15 sequencer steps on one shared 27x27 multiply-accumulate (three
// squares, three dot terms, cosine squared, seven wide partial products,
// decide); later candidates are dropped. A last candidate leads to ST_EMIT,
// which loads the result register. Asynchronous active-low reset; no clearing
// pass. A held output result stalls only ST_EMIT, which holds off new items.
module cone_range_target_select import crts_pkg::*; #(
  parameter int unsigned MAX_CANDIDATES = MaxCandDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  crts_stream_if.sink           cand_i,
  crts_stream_if.source         result_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i
);

  localparam int CntW    = $clog2(MAX_CANDIDATES + 1);
  localparam int IdxW    = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int IdxExtW = (IdxW > IdxOutW) ? IdxW : IdxOutW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef enum logic [3:0] {
    S_SQ_X, S_SQ_Y, S_SQ_Z,
    S_DOT_X, S_DOT_Y, S_DOT_Z,
    S_CC,
    S_DM_LL, S_DM_LH, S_DM_HH,
    S_CD_LL, S_CD_LH, S_CD_HL, S_CD_HH,
    S_DECIDE
  } step_e;

  function automatic logic signed [DirW-1:0] sat_dir(input logic signed [CoordW-1:0] v);
    logic signed [CoordW-1:0] hi;
    logic signed [CoordW-1:0] lo;
    hi = CoordW'(32'sd32767);
    lo = CoordW'(-32'sd32768);
    if (v > hi) begin
      return DirW'(hi);
    end else if (v < lo) begin
      return DirW'(lo);
    end
    return DirW'(v);
  endfunction

  // configuration
  logic [DistW-1:0]       min_dist_q, max_dist_q;
  logic signed [CosW-1:0] cone_cos_q;

  // query and scan state
  state_e                   state_q, state_d;
  step_e                    step_q, step_d;
  logic signed [CoordW-1:0] origin_q [3];
  logic signed [CoordW-1:0] origin_d [3];
  logic signed [DirW-1:0]   dir_q [3];
  logic signed [DirW-1:0]   dir_d [3];
  logic [ModeW-1:0]         mode_q, mode_d;
  logic signed [StartW-1:0] skip_q, skip_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [IdxW-1:0]          best_idx_q, best_idx_d;
  logic [DistW-1:0]         best_dist_q, best_dist_d;
  logic                     have_best_q, have_best_d;
  logic                     out_valid_q, out_valid_d;

  // per-candidate working values
  logic signed [OffW-1:0] off_q [3];
  logic                   last_q;
  logic [DistW-1:0]       d2_q;
  logic                   dot_neg_q;
  logic [DmagW-1:0]       dmag_q;
  logic [CcW-1:0]         cc_q;
  result_item_t           out_item_q;

  logic                   in_acc;
  logic                   cnt_room;
  logic                   load_out;
  cand_item_t             in_item;

  mac_ctl_t               mac_ctl;
  logic signed [MulW-1:0] mac_a, mac_b;
  logic signed [AccW-1:0] acc;

  logic [DotW-1:0]        dot_w;
  logic [DmagW-1:0]       dmag_d;
  logic [CosW-1:0]        cmag;
  logic                   r_ge, r_le, c_ge0, c_le0, cone_ok, range_ok, elig, take;
  logic [IdxExtW-1:0]     idx_ext;

  assign in_item      = cand_i.payload;
  assign cand_i.ready = (state_q == ST_IDLE);
  assign in_acc       = cand_i.valid && cand_i.ready;
  assign cnt_room     = cnt_q < CntW'(MAX_CANDIDATES);

  assign cmag   = cone_cos_q[CosW-1] ? CosW'(-cone_cos_q) : cone_cos_q;
  assign dot_w  = acc[DotW-1:0];
  assign dmag_d = dot_w[DotW-1] ? DmagW'(-dot_w) : dot_w[DmagW-1:0];

  // shared multiply-accumulate sequencing
  always_comb begin
    mac_ctl = '{en: 1'b0, clear: 1'b0, sub: 1'b0, shift: SH_0};
    mac_a   = '0;
    mac_b   = '0;
    if (state_q == ST_CALC) begin
      mac_ctl.en = 1'b1;
      case (step_q)
        S_SQ_X: begin
          mac_ctl.clear = 1'b1;
          mac_a = MulW'(off_q[0]);
          mac_b = MulW'(off_q[0]);
        end
        S_SQ_Y: begin
          mac_a = MulW'(off_q[1]);
          mac_b = MulW'(off_q[1]);
        end
        S_SQ_Z: begin
          mac_a = MulW'(off_q[2]);
          mac_b = MulW'(off_q[2]);
        end
        S_DOT_X: begin
          mac_ctl.clear = 1'b1;
          mac_a = MulW'(dir_q[0]);
          mac_b = MulW'(off_q[0]);
        end
        S_DOT_Y: begin
          mac_a = MulW'(dir_q[1]);
          mac_b = MulW'(off_q[1]);
        end
        S_DOT_Z: begin
          mac_a = MulW'(dir_q[2]);
          mac_b = MulW'(off_q[2]);
        end
        S_CC: begin
          mac_ctl.clear = 1'b1;
          mac_a = MulW'(cmag);
          mac_b = MulW'(cmag);
        end
        S_DM_LL: begin
          mac_ctl.clear = 1'b1;
          mac_a = MulW'(dmag_q[ChunkW-1:0]);
          mac_b = MulW'(dmag_q[ChunkW-1:0]);
        end
        S_DM_LH: begin
          // cross term counted twice
          mac_ctl.shift = SH_27;
          mac_a = MulW'(dmag_q[ChunkW-1:0]);
          mac_b = MulW'(dmag_q[DmagW-1:ChunkW]);
        end
        S_DM_HH: begin
          mac_ctl.shift = SH_52;
          mac_a = MulW'(dmag_q[DmagW-1:ChunkW]);
          mac_b = MulW'(dmag_q[DmagW-1:ChunkW]);
        end
        S_CD_LL: begin
          mac_ctl.sub = 1'b1;
          mac_a = MulW'(cc_q[ChunkW-1:0]);
          mac_b = MulW'(d2_q[ChunkW-1:0]);
        end
        S_CD_LH: begin
          mac_ctl.sub   = 1'b1;
          mac_ctl.shift = SH_26;
          mac_a = MulW'(cc_q[ChunkW-1:0]);
          mac_b = MulW'(d2_q[DistW-1:ChunkW]);
        end
        S_CD_HL: begin
          mac_ctl.sub   = 1'b1;
          mac_ctl.shift = SH_26;
          mac_a = MulW'(cc_q[CcW-1:ChunkW]);
          mac_b = MulW'(d2_q[ChunkW-1:0]);
        end
        S_CD_HH: begin
          mac_ctl.sub   = 1'b1;
          mac_ctl.shift = SH_52;
          mac_a = MulW'(cc_q[CcW-1:ChunkW]);
          mac_b = MulW'(d2_q[DistW-1:ChunkW]);
        end
        default: mac_ctl.en = 1'b0;
      endcase
    end
  end

  crts_mac u_crts_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  // at S_DECIDE the accumulator holds |dot|^2 - cos^2 * d2
  always_comb begin
    r_ge     = !acc[AccW-1];
    r_le     = acc[AccW-1] || (acc == '0);
    c_ge0    = !cone_cos_q[CosW-1];
    c_le0    = cone_cos_q[CosW-1] || (cone_cos_q == '0);
    if (d2_q == '0) begin
      cone_ok = c_le0;  // zero offset: dot taken as zero
    end else if (c_ge0) begin
      cone_ok = !dot_neg_q && r_ge;
    end else begin
      cone_ok = !dot_neg_q || r_le;
    end
    range_ok = (d2_q >= min_dist_q) && (d2_q <= max_dist_q);
    elig     = range_ok && ((mode_q == MODE_NEAR_RANGE) || cone_ok);
    case (mode_q)
      MODE_FIRST:    take = elig && !have_best_q && ($signed({1'b0, cnt_q}) > skip_q);
      MODE_FARTHEST: take = elig && (d2_q > best_dist_q);
      default:       take = elig && (!have_best_q || (d2_q < best_dist_q));
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    origin_d    = origin_q;
    dir_d       = dir_q;
    mode_d      = mode_q;
    skip_d      = skip_q;
    cnt_d       = cnt_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    have_best_d = have_best_q;
    load_out    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.op)
            OP_ORIGIN: begin
              origin_d[0] = in_item.coord_x;
              origin_d[1] = in_item.coord_y;
              origin_d[2] = in_item.coord_z;
              mode_d      = in_item.query_mode;
              skip_d      = in_item.start_after;
              cnt_d       = '0;
              best_idx_d  = '0;
              best_dist_d = '0;
              have_best_d = 1'b0;
            end
            OP_DIR: begin
              dir_d[0] = sat_dir(in_item.coord_x);
              dir_d[1] = sat_dir(in_item.coord_y);
              dir_d[2] = sat_dir(in_item.coord_z);
            end
            OP_CAND: begin
              if (cnt_room) begin
                state_d = ST_CALC;
                step_d  = S_SQ_X;
              end else if (in_item.last) begin
                state_d = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        if (step_q == S_DECIDE) begin
          if (take) begin
            have_best_d = 1'b1;
            best_idx_d  = cnt_q[IdxW-1:0];
            best_dist_d = d2_q;
          end
          cnt_d   = cnt_q + CntW'(1);
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          step_d = step_e'(step_q + 4'd1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          load_out    = 1'b1;
          cnt_d       = '0;
          best_idx_d  = '0;
          best_dist_d = '0;
          have_best_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = (out_valid_q && !result_o.ready) || load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q  <= '0;
      max_dist_q  <= '1;
      cone_cos_q  <= '0;
      state_q     <= ST_IDLE;
      step_q      <= S_SQ_X;
      origin_q    <= '{default: '0};
      dir_q       <= '{default: '0};
      mode_q      <= MODE_FIRST;
      skip_q      <= '1;
      cnt_q       <= '0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_DIST: min_dist_q <= cfg_wdata_i[DistW-1:0];
          CFG_MAX_DIST: max_dist_q <= cfg_wdata_i[DistW-1:0];
          CFG_CONE_COS: cone_cos_q <= cfg_wdata_i[CosW-1:0];
          default: ;
        endcase
      end
      state_q     <= state_d;
      step_q      <= step_d;
      origin_q    <= origin_d;
      dir_q       <= dir_d;
      mode_q      <= mode_d;
      skip_q      <= skip_d;
      cnt_q       <= cnt_d;
      best_idx_q  <= best_idx_d;
      best_dist_q <= best_dist_d;
      have_best_q <= have_best_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign idx_ext = IdxExtW'(best_idx_q);

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_item.op == OP_CAND)) begin
      off_q[0] <= OffW'(in_item.coord_x) - OffW'(origin_q[0]);
      off_q[1] <= OffW'(in_item.coord_y) - OffW'(origin_q[1]);
      off_q[2] <= OffW'(in_item.coord_z) - OffW'(origin_q[2]);
      last_q   <= in_item.last;
    end
    if (state_q == ST_CALC) begin
      if (step_q == S_DOT_X) begin
        d2_q <= acc[DistW-1:0];
      end
      if (step_q == S_CC) begin
        dot_neg_q <= dot_w[DotW-1];
        dmag_q    <= dmag_d;
      end
      if (step_q == S_DM_LL) begin
        cc_q <= acc[CcW-1:0];
      end
    end
    if (load_out) begin
      out_item_q.found        <= have_best_q;
      out_item_q.best_index   <= have_best_q ? idx_ext[IdxOutW-1:0] : '0;
      out_item_q.best_dist_sq <= have_best_q ? best_dist_q : '0;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_item_q;

endmodule

// ===== hw/rtl/crts_checker.sv =====
module crts_checker import crts_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [OpW-1:0]   in_op_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input result_item_t     out_item_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_item_i))
    else $error("result item changed while stalled");

  // no selection must report index and distance as zero
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.found |->
      (out_item_i.best_index == '0) && (out_item_i.best_dist_sq == '0))
    else $error("empty result carries nonzero fields");

  // origin and direction items finish in their accept cycle
  a_setup_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && ((in_op_i == OP_ORIGIN) || (in_op_i == OP_DIR))
      |=> in_ready_i)
    else $error("setup item held the input");

endmodule

bind cone_range_target_select crts_checker u_crts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cand_i.valid),
  .in_ready_i  (cand_i.ready),
  .in_op_i     (cand_i.payload.op),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_item_i  (result_o.payload)
);

// ===== bench/cone_range_target_select_tb.sv =====
module cone_range_target_select_tb;
  import crts_pkg::*;

  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned DrainCycles = 24;     // one candidate plus result load, with margin
  localparam logic [DistW-1:0]   DistMax     = {DistW{1'b1}};
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  crts_stream_if #(.T(cand_item_t))   cand_if ();
  crts_stream_if #(.T(result_item_t)) res_if ();

  cone_range_target_select i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cand_i      (cand_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state
  logic [DistW-1:0]      cfg_min = '0;
  logic [DistW-1:0]      cfg_max = DistMax;
  logic signed [CosW-1:0] cfg_cos = '0;
  longint                org_q [3] = '{0, 0, 0};
  longint                dir_q [3] = '{0, 0, 0};
  mode_e                 mode_q = MODE_FIRST;
  int                    skip_q = -1;
  int unsigned           cand_cnt = 0;
  logic [IdxOutW-1:0]    pick_idx = '0;
  logic [DistW-1:0]      pick_dist = '0;
  bit                    have_pick = 1'b0;

  result_item_t pick_queue [$];
  int unsigned  fail_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  settings_used = 0;
  int unsigned  cycle_count = 0;
  int           burst_left = 0;
  bit           gaps_on = 1'b1;
  int           stall_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count++;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
             pick_queue.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_scan();
    cand_cnt  = 0;
    pick_idx  = '0;
    pick_dist = '0;
    have_pick = 1'b0;
  endfunction

  // Returns 1 when the item closes a roster; pick then holds the expected result.
  function automatic bit predict_pick(input cand_item_t it, output result_item_t pick);
    longint       pos [3];
    longint       off [3];
    longint       dot;
    longint       cosv;
    logic [63:0]  d2;
    logic [63:0]  dmag;
    logic [63:0]  cmag;
    logic [127:0] dot_sq;
    logic [127:0] cos_d2;
    bit           ok;
    bit           take;
    pick   = '0;
    pos[0] = it.coord_x;
    pos[1] = it.coord_y;
    pos[2] = it.coord_z;
    case (it.op)
      OP_ORIGIN: begin
        for (int i = 0; i < 3; i++) org_q[i] = pos[i];
        mode_q = mode_e'(it.query_mode);
        skip_q = it.start_after;
        clear_scan();
        return 1'b0;
      end
      OP_DIR: begin
        for (int i = 0; i < 3; i++) begin
          dir_q[i] = pos[i] > 32767 ? 32767 : (pos[i] < -32768 ? -32768 : pos[i]);
        end
        return 1'b0;
      end
      OP_CAND: ;
      default: return 1'b0;
    endcase

    if (cand_cnt < MaxCandDefault) begin
      d2 = '0;
      for (int i = 0; i < 3; i++) begin
        off[i] = pos[i] - org_q[i];
        d2 = d2 + off[i] * off[i];
      end
      ok = (d2 >= cfg_min) && (d2 <= cfg_max);
      if (ok && mode_q != MODE_NEAR_RANGE) begin
        cosv = cfg_cos;
        if (d2 == 0) begin
          // zero offset: dot product counts as zero
          ok = (cosv <= 0);
        end else begin
          dot    = dir_q[0] * off[0] + dir_q[1] * off[1] + dir_q[2] * off[2];
          dmag   = dot < 0 ? -dot : dot;
          cmag   = cosv < 0 ? -cosv : cosv;
          dot_sq = dmag * dmag;
          cos_d2 = (cmag * cmag) * d2;
          if (cosv >= 0) ok = (dot >= 0) && (dot_sq >= cos_d2);
          else ok = (dot >= 0) || (dot_sq <= cos_d2);
        end
      end
      take = 1'b0;
      if (ok) begin
        case (mode_q)
          MODE_FIRST:    take = !have_pick && (int'(cand_cnt) > skip_q);
          MODE_FARTHEST: take = d2 > pick_dist;
          default:       take = !have_pick || d2 < pick_dist;
        endcase
      end
      if (take) begin
        have_pick = 1'b1;
        pick_idx  = cand_cnt[IdxOutW-1:0];
        pick_dist = d2[DistW-1:0];
      end
      cand_cnt++;
    end

    if (!it.last) return 1'b0;
    pick.found        = have_pick;
    pick.best_index   = have_pick ? pick_idx : '0;
    pick.best_dist_sq = have_pick ? pick_dist : '0;
    clear_scan();
    return 1'b1;
  endfunction

  function automatic cand_item_t make_cand(input op_e op, input longint x, input longint y,
                                           input longint z, input int mode, input int start,
                                           input int last);
    cand_item_t it;
    it.op          = op;
    it.coord_x     = CoordW'(x);
    it.coord_y     = CoordW'(y);
    it.coord_z     = CoordW'(z);
    it.query_mode  = ModeW'(mode);
    it.start_after = StartW'(start);
    it.last        = (last != 0);
    return it;
  endfunction

  function automatic longint rand_coord();
    logic signed [CoordW-1:0] full;
    full = CoordW'($urandom);
    case ($urandom_range(0, 9))
      0:       return full;
      1, 2:    return longint'($urandom_range(0, 1 << 17)) - (1 << 16);
      default: return longint'($urandom_range(0, 1 << 12)) - (1 << 11);
    endcase
  endfunction

  task automatic send_item(input cand_item_t it);
    result_item_t pick;
    if (burst_left == 0) begin
      if (gaps_on) begin
        cand_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    cand_if.valid   <= 1'b1;
    cand_if.payload <= it;
    do @(posedge clk_i); while (cand_if.ready !== 1'b1);
    burst_left--;
    if (it.op != OP_NONE) items_sent++;
    if (predict_pick(it, pick)) pick_queue.push_back(pick);
  endtask

  // sender pauses until every pick is back and the block has drained
  task automatic wait_idle();
    cand_if.valid <= 1'b0;
    burst_left = 0;
    while (pick_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [DistW-1:0] lo, input logic [DistW-1:0] hi,
                               input logic signed [CosW-1:0] cosv, input bit poke_spare);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MIN_DIST;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAX_DIST;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CONE_COS;
    cfg_wdata_i <= CfgDataW'(cosv);
    @(posedge clk_i);
    if (poke_spare) begin
      // unused index must leave all registers alone
      cfg_idx_i   <= CfgIdxSpare;
      cfg_wdata_i <= CfgDataW'({$urandom, $urandom});
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_min  = lo;
    cfg_max  = hi;
    cfg_cos  = cosv;
    settings_used++;
  endtask

  // origin, usually a direction, then n_cand candidates; the last one closes the roster
  task automatic send_roster(input int n_cand);
    longint org [3];
    longint dir [3];
    longint pos [3];
    longint k;
    logic signed [CoordW-1:0] full;
    bit aligned;
    for (int i = 0; i < 3; i++) begin
      org[i] = rand_coord();
      full   = CoordW'($urandom);
      case ($urandom_range(0, 7))
        0:       dir[i] = full;      // beyond Q1.15, saturates
        1:       dir[i] = 0;
        2:       dir[i] = 32767;
        3:       dir[i] = -32768;
        default: dir[i] = longint'($urandom_range(0, 65535)) - 32768;
      endcase
    end
    send_item(make_cand(OP_ORIGIN, org[0], org[1], org[2], $urandom_range(0, 3),
                        $urandom_range(0, 15), $urandom_range(0, 1)));
    if ($urandom_range(0, 6) != 0) begin
      send_item(make_cand(OP_DIR, dir[0], dir[1], dir[2], $urandom_range(0, 3),
                          $urandom_range(0, 15), $urandom_range(0, 1)));
    end
    for (int c = 0; c < n_cand; c++) begin
      k       = $urandom_range(0, 4096);
      aligned = $urandom_range(0, 9) < 4;
      for (int i = 0; i < 3; i++) begin
        // aligned candidates sit near the look direction so cone tests can pass
        pos[i] = org[i] + (aligned ? ((dir[i] * k) >>> 15) + $urandom_range(0, 6) - 3
                                   : rand_coord());
      end
      send_item(make_cand(OP_CAND, pos[0], pos[1], pos[2], $urandom_range(0, 3),
                          $urandom_range(0, 15), c == n_cand - 1));
    end
  endtask

  task automatic test_special_cases();
    apply_setting('0, DistMax, '0, 1'b1);
    // corner origin, saturating direction, largest distance, zero offset
    send_item(make_cand(OP_ORIGIN, -8388608, -8388608, -8388608, MODE_NEAR_RANGE, -1, 1'b0));
    send_item(make_cand(OP_DIR, 8388607, -8388608, 100, MODE_FIRST, 0, 1'b1));
    send_item(make_cand(OP_CAND, 8388607, 8388607, 8388607, MODE_FARTHEST, 7, 1'b0));
    send_item(make_cand(OP_CAND, -8388608, -8388608, -8388608, MODE_FIRST, 0, 1'b1));
    send_item(make_cand(OP_NONE, 123, -5, 77, MODE_FARTHEST, 3, 1'b1));
    // first mode, start index below -1, zero offset with cosine zero
    send_item(make_cand(OP_ORIGIN, 0, 0, 0, MODE_FIRST, -8, 1'b1));
    send_item(make_cand(OP_DIR, 32767, 0, 0, MODE_NEAR_CONE, 5, 1'b0));
    send_item(make_cand(OP_CAND, 0, 0, 0, MODE_NEAR_CONE, 2, 1'b0));
    send_item(make_cand(OP_CAND, 256, 0, 0, MODE_FIRST, 0, 1'b1));
    wait_idle();

    // positive cosine rejects zero offset and candidates behind the direction
    apply_setting('0, DistMax, 17'sd32768, 1'b0);
    send_item(make_cand(OP_ORIGIN, 0, 0, 0, MODE_NEAR_CONE, -1, 1'b0));
    send_item(make_cand(OP_CAND, 0, 0, 0, MODE_FIRST, 0, 1'b0));
    send_item(make_cand(OP_CAND, -256, 0, 0, MODE_FIRST, 0, 1'b0));
    send_item(make_cand(OP_CAND, 512, 1, 0, MODE_FIRST, 0, 1'b1));
    wait_idle();

    // most negative cosine, farthest mode, roster longer than the candidate limit
    apply_setting('0, DistMax, 17'h10000, 1'b0);
    send_item(make_cand(OP_ORIGIN, 1000, -1000, 0, MODE_FARTHEST, 0, 1'b0));
    for (int c = 0; c < 10; c++) begin
      send_item(make_cand(OP_CAND, c == 0 ? 1000 : rand_coord(), c == 0 ? -1000 : rand_coord(),
                          c == 0 ? 0 : rand_coord(), MODE_FIRST, 0, c == 9));
    end
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    apply_setting('0, DistMax, '0, 1'b0);
    gaps_on    = 1'b0;
    stall_hold = 600;
    for (int r = 0; r < 12; r++) send_roster($urandom_range(1, 2));
    gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_rosters();
    int unsigned      target;
    logic [DistW-1:0] lo;
    logic [DistW-1:0] hi;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: apply_setting('0, DistMax, '0, 1'b0);
        1: apply_setting('0, DistMax, 17'sd23170, 1'b0);
        2: apply_setting(DistW'(64'd1 << 16), DistW'(64'd1 << 36), -17'sd16384, 1'b0);
        3: apply_setting('0, DistMax, 17'sd32768, 1'b0);
        4: apply_setting('0, DistW'(64'd1 << 30), 17'h10000, 1'b0);
        5: apply_setting('0, DistMax, 17'sd65535, 1'b0);
        6: apply_setting(DistMax, DistMax, -17'sd32768, 1'b0);
        7: begin
          lo = DistW'($urandom_range(0, 1 << 24));
          hi = lo + (DistW'({$urandom, $urandom}) >> $urandom_range(0, 30));
          apply_setting(lo, hi, CosW'(int'($urandom_range(0, 65536)) - 32768), 1'b1);
        end
        default: apply_setting(DistW'(1 << 20), DistW'(1 << 10), '0, 1'b0);  // empty band
      endcase
      gaps_on = (ph % 3) != 2;
      target  = items_sent + 100;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) != 0) begin
          send_roster($urandom_range(0, 9) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 8));
        end else begin
          // stray item: any op, including direction mid-roster and ignored op
          send_item(make_cand(op_e'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                              rand_coord(), $urandom_range(0, 3), $urandom_range(0, 15),
                              $urandom_range(0, 1)));
        end
      end
      wait_idle();
    end
  endtask

  // result receiver: stall pattern in segments, long hold-off on request
  initial begin
    int seg_left;
    int seg_kind;
    res_if.ready <= 1'b0;
    seg_left = 0;
    seg_kind = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_hold > 0) begin
        res_if.ready <= 1'b0;
        stall_hold--;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 150);
          seg_kind = $urandom_range(0, 3);
        end
        seg_left--;
        case (seg_kind)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= ($urandom_range(0, 1) == 1);
          2:       res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (seg_left % 5) != 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    result_item_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pick_queue.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual found=%0b idx=%0d dist=%0d",
                 $time, res_if.payload.found, res_if.payload.best_index,
                 res_if.payload.best_dist_sq);
      end else begin
        want = pick_queue.pop_front();
        results_seen++;
        if (res_if.payload.found !== want.found) begin
          fail_count++;
          $display("%0t: found expected %0b actual %0b", $time, want.found,
                   res_if.payload.found);
        end
        if (res_if.payload.best_index !== want.best_index) begin
          fail_count++;
          $display("%0t: best_index expected %0d actual %0d", $time, want.best_index,
                   res_if.payload.best_index);
        end
        if (res_if.payload.best_dist_sq !== want.best_dist_sq) begin
          fail_count++;
          $display("%0t: best_dist_sq expected %0d actual %0d", $time, want.best_dist_sq,
                   res_if.payload.best_dist_sq);
        end
      end
    end
  end

  initial begin
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_wdata_i     <= '0;
    cand_if.valid   <= 1'b0;
    cand_if.payload <= '0;
    rst_ni          <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_output_backpressure();
    test_random_rosters();

    $display("Sent %0d items, checked %0d results over %0d register settings.",
             items_sent, results_seen, settings_used);
    $display("Covered all query modes, band and cone limits, saturation and output stalls.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
